>>> rtl/ksu_pkg.sv
package ksu_pkg;

    localparam int AXES      = 3;
    localparam int AX_W      = (AXES > 1) ? $clog2(AXES) : 1;
    localparam int DIV_STEPS = 48;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam int APB_AW    = 4;

    typedef logic signed [31:0] q_t;
    typedef q_t [AXES-1:0] row_t;
    typedef row_t [AXES-1:0] mat_t;

    typedef struct packed {
        logic clip;
        q_t   val;
    } sat_t;

    typedef struct packed {
        logic restart;
        q_t   accel_x;
        q_t   accel_y;
        q_t   accel_z;
    } in_word_t;

    typedef struct packed {
        q_t   smooth_x;
        q_t   smooth_y;
        q_t   smooth_z;
        logic saturated;
    } out_word_t;

    typedef enum logic [3:0] {
        LN_NOP,
        LN_CLEAR,
        LN_EP_MUL,
        LN_EP_ADD,
        LN_DIV_ST,
        LN_UP_SUB,
        LN_UP_MUL,
        LN_UP_ADD,
        LN_SH_MUL,
        LN_SH_SUB
    } lane_cmd_t;

    typedef struct packed {
        logic k_ready;
        logic clip;
        logic wr_en;
        q_t   wr_val;
    } lane_stat_t;

    typedef struct packed {
        logic clear;
        logic start;
    } cov_ctl_t;

    typedef enum logic [1:0] {
        CP_IDLE,
        CP_SUM,
        CP_MUL,
        CP_ACC
    } cov_state_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_EP_MUL,
        S_EP_ADD,
        S_COV_ST,
        S_COV_WAIT,
        S_DIV_ST,
        S_DIV_WAIT,
        S_UP_SUB,
        S_UP_MUL,
        S_UP_ADD,
        S_SH_MUL,
        S_SH_SUB,
        S_OUT
    } ctl_state_t;

    localparam logic [1:0] REG_TIME_STEP  = 2'd0;
    localparam logic [1:0] REG_PROC_NOISE = 2'd1;
    localparam logic [1:0] REG_MEAS_NOISE = 2'd2;
    localparam logic [1:0] REG_ITER_COUNT = 2'd3;

    // clip a wide signed value to the Q16.16 range
    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t s;
        if (v > 64'sh000000007FFFFFFF)
        begin
            s.clip = 1'b1;
            s.val  = 32'sh7FFFFFFF;
        end
        else if (v < 64'shFFFFFFFF80000000)
        begin
            s.clip = 1'b1;
            s.val  = 32'sh80000000;
        end
        else
        begin
            s.clip = 1'b0;
            s.val  = v[31:0];
        end
        return s;
    endfunction

endpackage

>>> rtl/three_axis_kalman_smoother_unit.sv
// Channel | Handshake            | Word
// --------+----------------------+---------------------------------------
// in      | in_valid / in_stall  | in_data: restart, accel_x/y/z
// out     | out_valid / out_stall| out_data: smooth_x/y/z, saturated
// cfg     | APB psel/penable     | time_step, noises, iteration_count
// The time per sample is set by the 48-step gain divider in each axis lane
// and by the serial nine-entry covariance pass.
// Samples are handled one at a time; in_stall is high while one is in work.
// A finished word waits in the output register while the next sample runs.
// Reset clears estimate, covariance and registers to their defaults.
module three_axis_kalman_smoother_unit import ksu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              in_valid,
    output logic              in_stall,
    input  in_word_t          in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output out_word_t         out_data
);

    logic [15:0]       time_step_reg;
    logic [30:0]       proc_noise_reg;
    logic [30:0]       meas_noise_reg;
    logic [7:0]        iter_count_reg;

    ctl_state_t        state_reg;
    ctl_state_t        state_next;
    row_t              meas_reg;
    logic              restart_reg;
    logic [7:0]        iter_reg;
    logic [AX_W-1:0]   col_reg;
    logic              clip_reg;
    logic              out_valid_reg;
    out_word_t         out_data_reg;

    lane_cmd_t         cmd;
    cov_ctl_t          cov_ctl;
    mat_t              mat;
    logic              cov_done;
    logic              cov_clip;
    row_t              est;
    lane_stat_t [AXES-1:0] stat;
    logic [AXES-1:0]   k_ready;
    logic [AXES-1:0]   lane_clip;
    logic [AXES-1:0]   wr_en;
    row_t              wr_val;
    q_t [2:0]          acc_all;
    q_t [2:0]          est_all;
    logic              cfg_wr;
    logic              col_last;
    logic              out_go;

    assign pready   = 1'b1;
    assign cfg_wr   = psel & penable & pwrite;
    assign acc_all  = {in_data.accel_z, in_data.accel_y, in_data.accel_x};
    assign col_last = (col_reg == AX_W'(AXES - 1));
    assign out_go   = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        case (paddr[3:2])
            REG_TIME_STEP:  prdata = {16'b0, time_step_reg};
            REG_PROC_NOISE: prdata = {1'b0, proc_noise_reg};
            REG_MEAS_NOISE: prdata = {1'b0, meas_noise_reg};
            REG_ITER_COUNT: prdata = {24'b0, iter_count_reg};
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            time_step_reg  <= 16'd655;
            proc_noise_reg <= 31'd6554;
            meas_noise_reg <= 31'd65536;
            iter_count_reg <= 8'd100;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_TIME_STEP:  time_step_reg  <= pwdata[15:0];
                REG_PROC_NOISE: proc_noise_reg <= pwdata[30:0];
                REG_MEAS_NOISE: meas_noise_reg <= pwdata[30:0];
                REG_ITER_COUNT: iter_count_reg <= pwdata[7:0];
                default:        time_step_reg  <= time_step_reg;
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < AXES; g++)
        begin : g_lane
            ksu_lane u_lane
            (
                .clk   (clk),
                .rst_n (rst_n),
                .cmd   (cmd),
                .col   (col_reg),
                .meas  (meas_reg[g]),
                .row   (mat[g]),
                .diag  (mat[g][g]),
                .dt    (time_step_reg),
                .r     (meas_noise_reg),
                .est   (est[g]),
                .stat  (stat[g])
            );
            assign k_ready[g]   = stat[g].k_ready;
            assign lane_clip[g] = stat[g].clip;
            assign wr_en[g]     = stat[g].wr_en;
            assign wr_val[g]    = stat[g].wr_val;
        end
        for (g = 0; g < 3; g++)
        begin : g_out
            if (g < AXES)
            begin : g_used
                assign est_all[g] = est[g];
            end
            else
            begin : g_unused
                assign est_all[g] = '0;
            end
        end
    endgenerate

    ksu_cov u_cov
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cov_ctl),
        .dt     (time_step_reg),
        .q      (proc_noise_reg),
        .col    (col_reg),
        .wr_en  (wr_en),
        .wr_val (wr_val),
        .mat    (mat),
        .done   (cov_done),
        .clip   (cov_clip)
    );

    always_comb
    begin
        case (state_reg)
            S_IDLE:     state_next = in_valid ? S_LOAD : S_IDLE;
            S_LOAD:     state_next = (iter_count_reg == 8'd0) ? S_OUT : S_EP_MUL;
            S_EP_MUL:   state_next = S_EP_ADD;
            S_EP_ADD:   state_next = S_COV_ST;
            S_COV_ST:   state_next = S_COV_WAIT;
            S_COV_WAIT: state_next = cov_done ? S_DIV_ST : S_COV_WAIT;
            S_DIV_ST:   state_next = S_DIV_WAIT;
            S_DIV_WAIT: state_next = (&k_ready) ? S_UP_SUB : S_DIV_WAIT;
            S_UP_SUB:   state_next = S_UP_MUL;
            S_UP_MUL:   state_next = S_UP_ADD;
            S_UP_ADD:   state_next = S_SH_MUL;
            S_SH_MUL:   state_next = S_SH_SUB;
            S_SH_SUB:
            begin
                if (!col_last)
                    state_next = S_SH_MUL;
                else if (iter_reg == 8'd1)
                    state_next = S_OUT;
                else
                    state_next = S_EP_MUL;
            end
            S_OUT:      state_next = out_go ? S_IDLE : S_OUT;
            default:    state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cov_ctl.clear = (state_reg == S_LOAD) && restart_reg;
        cov_ctl.start = (state_reg == S_COV_ST);
        case (state_reg)
            S_LOAD:   cmd = restart_reg ? LN_CLEAR : LN_NOP;
            S_EP_MUL: cmd = LN_EP_MUL;
            S_EP_ADD: cmd = LN_EP_ADD;
            S_DIV_ST: cmd = LN_DIV_ST;
            S_UP_SUB: cmd = LN_UP_SUB;
            S_UP_MUL: cmd = LN_UP_MUL;
            S_UP_ADD: cmd = LN_UP_ADD;
            S_SH_MUL: cmd = LN_SH_MUL;
            S_SH_SUB: cmd = LN_SH_SUB;
            default:  cmd = LN_NOP;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            iter_reg      <= '0;
            col_reg       <= '0;
            clip_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_LOAD)
                clip_reg <= 1'b0;
            else
                clip_reg <= clip_reg | (|lane_clip) | cov_clip;
            if (state_reg == S_LOAD)
                iter_reg <= iter_count_reg;
            else if (state_reg == S_SH_SUB && col_last)
                iter_reg <= iter_reg - 8'd1;
            if (state_reg == S_UP_ADD)
                col_reg <= '0;
            else if (state_reg == S_SH_SUB)
                col_reg <= col_last ? '0 : col_reg + AX_W'(1);
            if (state_reg == S_OUT && out_go)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            restart_reg <= in_data.restart;
            for (int a = 0; a < AXES; a++)
                meas_reg[a] <= acc_all[a];
        end
        if (state_reg == S_OUT && out_go)
        begin
            out_data_reg.smooth_x  <= est_all[0];
            out_data_reg.smooth_y  <= est_all[1];
            out_data_reg.smooth_z  <= est_all[2];
            out_data_reg.saturated <= clip_reg;
        end
    end

`ifndef NO_ASSERTIONS
    a_accept_load: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_LOAD)
        else $error("accepted word did not start a sample");

    a_gain_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_UP_SUB |-> (&k_ready))
        else $error("update started before all gains were ready");

    a_iter_live: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EP_MUL |-> iter_reg != 8'd0)
        else $error("round started with no iterations left");

    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_OUT))
        else $error("result word appeared outside the output state");
`endif

endmodule

>>> rtl/ksu_lane.sv
module ksu_lane import ksu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  lane_cmd_t         cmd,
    input  logic [AX_W-1:0]   col,
    input  q_t                meas,
    input  row_t              row,
    input  q_t                diag,
    input  logic [15:0]       dt,
    input  logic [30:0]       r,
    output q_t                est,
    output lane_stat_t        stat
);

    q_t                  est_reg;
    q_t                  e_reg;
    q_t                  k_reg;
    logic signed [63:0]  prod_reg;
    logic [32:0]         rem_reg;
    logic [47:0]         num_reg;
    logic [31:0]         dmag_reg;
    logic                neg_reg;
    logic                zero_reg;
    logic                busy_reg;
    logic                fin_reg;
    logic                k_ready_reg;
    logic [CNT_W-1:0]    cnt_reg;

    q_t                  mul_a;
    q_t                  mul_b;
    q_t                  row_sel;
    sat_t                qm;
    sat_t                s_add;
    sat_t                s_err;
    sat_t                s_shr;
    sat_t                s_den;
    sat_t                k_fin;
    logic [31:0]         diag_abs;
    logic [32:0]         rem_sh;
    logic                rem_ge;

    assign row_sel  = row[col];
    assign qm       = sat32(prod_reg >>> 16);
    assign s_add    = sat32(64'(est_reg) + 64'(qm.val));
    assign s_err    = sat32(64'(meas) - 64'(est_reg));
    assign s_shr    = sat32(64'(row_sel) - 64'(qm.val));
    assign s_den    = sat32(64'(diag) + 64'($signed({1'b0, r})));
    assign diag_abs = diag[31] ? 32'(-diag) : 32'(diag);
    assign rem_sh   = {rem_reg[31:0], num_reg[47]};
    assign rem_ge   = rem_sh >= {1'b0, dmag_reg};

    always_comb
    begin
        mul_a = k_reg;
        mul_b = e_reg;
        case (cmd)
            LN_EP_MUL:
            begin
                mul_a = $signed({16'b0, dt});
                mul_b = est_reg;
            end
            LN_SH_MUL:
            begin
                mul_b = row_sel;
            end
            default:
            begin
                mul_a = k_reg;
            end
        endcase
    end

    // signed quotient from the magnitude result
    always_comb
    begin
        k_fin.clip = 1'b0;
        k_fin.val  = '0;
        if (zero_reg)
        begin
            k_fin.val = '0;
        end
        else if (!neg_reg)
        begin
            if (num_reg > 48'h00007FFFFFFF)
            begin
                k_fin.clip = 1'b1;
                k_fin.val  = 32'sh7FFFFFFF;
            end
            else
            begin
                k_fin.val = num_reg[31:0];
            end
        end
        else if (num_reg > 48'h000080000000)
        begin
            k_fin.clip = 1'b1;
            k_fin.val  = 32'sh80000000;
        end
        else
        begin
            k_fin.val = -$signed(num_reg[31:0]);
        end
    end

    always_comb
    begin
        stat.k_ready = k_ready_reg;
        stat.wr_en   = (cmd == LN_SH_SUB);
        stat.wr_val  = s_shr.val;
        case (cmd)
            LN_EP_ADD: stat.clip = qm.clip | s_add.clip;
            LN_UP_ADD: stat.clip = qm.clip | s_add.clip;
            LN_UP_SUB: stat.clip = s_err.clip;
            LN_SH_SUB: stat.clip = qm.clip | s_shr.clip;
            LN_DIV_ST: stat.clip = s_den.clip;
            default:   stat.clip = fin_reg & k_fin.clip;
        endcase
    end

    assign est = est_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            est_reg     <= '0;
            busy_reg    <= 1'b0;
            fin_reg     <= 1'b0;
            k_ready_reg <= 1'b0;
            cnt_reg     <= '0;
        end
        else
        begin
            case (cmd)
                LN_CLEAR:  est_reg <= '0;
                LN_EP_ADD: est_reg <= s_add.val;
                LN_UP_ADD: est_reg <= s_add.val;
                default:   est_reg <= est_reg;
            endcase
            if (cmd == LN_DIV_ST)
            begin
                busy_reg    <= 1'b1;
                fin_reg     <= 1'b0;
                k_ready_reg <= 1'b0;
                cnt_reg     <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    fin_reg  <= 1'b1;
                end
            end
            else if (fin_reg)
            begin
                fin_reg     <= 1'b0;
                k_ready_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd == LN_EP_MUL || cmd == LN_UP_MUL || cmd == LN_SH_MUL)
            prod_reg <= 64'(mul_a) * 64'(mul_b);
        if (cmd == LN_UP_SUB)
            e_reg <= s_err.val;
        if (cmd == LN_DIV_ST)
        begin
            dmag_reg <= s_den.val[31] ? 32'(-s_den.val) : 32'(s_den.val);
            num_reg  <= {diag_abs, 16'b0};
            neg_reg  <= diag[31] ^ s_den.val[31];
            zero_reg <= (s_den.val == 0);
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (rem_ge)
            begin
                rem_reg <= rem_sh - {1'b0, dmag_reg};
                num_reg <= {num_reg[46:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh;
                num_reg <= {num_reg[46:0], 1'b0};
            end
        end
        else if (fin_reg)
        begin
            k_reg <= k_fin.val;
        end
    end

endmodule

>>> rtl/ksu_cov.sv
module ksu_cov import ksu_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  cov_ctl_t          ctl,
    input  logic [15:0]       dt,
    input  logic [30:0]       q,
    input  logic [AX_W-1:0]   col,
    input  logic [AXES-1:0]   wr_en,
    input  row_t              wr_val,
    output mat_t              mat,
    output logic              done,
    output logic              clip
);

    mat_t                cov_reg;
    cov_state_t          state_reg;
    cov_state_t          state_next;
    logic [AX_W-1:0]     i_reg;
    logic [AX_W-1:0]     j_reg;
    q_t                  t_reg;
    logic signed [63:0]  prod_reg;

    logic                last;
    logic                on_diag;
    sat_t                s_sum;
    sat_t                s_q;
    sat_t                qm;
    sat_t                s_acc;
    q_t                  t_val;

    assign last    = (i_reg == AX_W'(AXES - 1)) && (j_reg == AX_W'(AXES - 1));
    assign on_diag = (i_reg == j_reg);
    assign s_sum   = sat32(64'(cov_reg[i_reg][j_reg]) + 64'(cov_reg[j_reg][i_reg]));
    assign s_q     = sat32(64'(s_sum.val) + 64'($signed({1'b0, q})));
    assign t_val   = on_diag ? s_q.val : s_sum.val;
    assign qm      = sat32(prod_reg >>> 16);
    assign s_acc   = sat32(64'(cov_reg[i_reg][j_reg]) + 64'(qm.val));
    assign mat     = cov_reg;

    always_comb
    begin
        case (state_reg)
            CP_IDLE: state_next = ctl.start ? CP_SUM : CP_IDLE;
            CP_SUM:  state_next = CP_MUL;
            CP_MUL:  state_next = CP_ACC;
            CP_ACC:  state_next = last ? CP_IDLE : CP_SUM;
            default: state_next = CP_IDLE;
        endcase
    end

    always_comb
    begin
        done = 1'b0;
        clip = 1'b0;
        case (state_reg)
            CP_SUM:
            begin
                clip = s_sum.clip | (on_diag & s_q.clip);
            end
            CP_ACC:
            begin
                clip = qm.clip | s_acc.clip;
                done = last;
            end
            default:
            begin
                clip = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cov_reg   <= '0;
            state_reg <= CP_IDLE;
            i_reg     <= '0;
            j_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (ctl.clear)
            begin
                cov_reg <= '0;
            end
            else if (state_reg == CP_ACC)
            begin
                // row-major walk, so later entries see updated transposes
                cov_reg[i_reg][j_reg] <= s_acc.val;
                if (j_reg == AX_W'(AXES - 1))
                begin
                    j_reg <= '0;
                    i_reg <= last ? '0 : i_reg + AX_W'(1);
                end
                else
                begin
                    j_reg <= j_reg + AX_W'(1);
                end
            end
            else
            begin
                for (int a = 0; a < AXES; a++)
                begin
                    if (wr_en[a])
                        cov_reg[a][col] <= wr_val[a];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == CP_SUM)
            t_reg <= t_val;
        if (state_reg == CP_MUL)
            prod_reg <= 64'($signed({1'b0, dt})) * 64'(t_reg);
    end

endmodule
